// ===== hw/rtl/bhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bhs_pkg: shared types and constants of the brake-hold sequencer
// Register indexes, reset values, field widths and the status record that
// passes between the hold state machine and the frame builder.
// ----------------------------------------------------------------------------
package bhs_pkg;

    localparam int unsigned AccelW   = 16;
    localparam int unsigned SpeedW   = 17;
    localparam int unsigned JerkW    = 10;
    localparam int unsigned TargetW  = 14;
    localparam int unsigned LingerW  = 4;
    localparam int unsigned BlindW   = 8;
    localparam int unsigned CfgDataW = 17;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned OemW     = 56;
    localparam int unsigned FrameW   = 64;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_JERK_STEP    = 3'd0,
        CFG_STOP_TARGET  = 3'd1,
        CFG_ENGAGE_SPEED = 3'd2,
        CFG_LINGER_TICKS = 3'd3,
        CFG_BLIND_TICKS  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_FRAME = 1'b1
    } t_op;

    localparam logic [JerkW-1:0]   JerkReset   = 10'd14;
    localparam logic [TargetW-1:0] TargetReset = 14'h3060;  // -4000
    localparam logic [SpeedW-1:0]  SpeedReset  = 17'd18000;
    localparam logic [LingerW-1:0] LingerReset = 4'd10;
    localparam logic [BlindW-1:0]  BlindReset  = 8'd150;

    // Deceleration byte: floor((brake + DecelOffset) / 48), saturated.
    localparam logic signed [AccelW:0] DecelOffset = 17'sd7968;
    localparam logic signed [AccelW:0] DecelSatAt  = 17'sd12288;  // 256 * 48
    localparam logic [9:0]             RecipThree  = 10'd683;     // 2^11 / 3, rounded up

    typedef struct packed {
        logic [JerkW-1:0]          jerk_step;
        logic signed [TargetW-1:0] stop_target;
        logic [SpeedW-1:0]         engage_speed;
        logic [LingerW-1:0]        linger_ticks;
        logic [BlindW-1:0]         blind_ticks;
    } t_cfg;

    typedef struct packed {
        logic                     standby;
        logic                     is_stopping;
        logic                     override_any;
    } t_tick_flags;

    typedef struct packed {
        logic                     enabled;
        logic                     active;
        logic                     blind;
        logic signed [AccelW-1:0] brake_now;
    } t_hold_status;

endpackage

// ===== hw/rtl/bhs_hold.sv =====
// ----------------------------------------------------------------------------
// bhs_hold: hold state machine
// Holds the engage, brake, blind and release-tail state and steps it once for
// each tick beat. Reports the state before and after the step.
// ----------------------------------------------------------------------------
module bhs_hold (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  bhs_pkg::t_cfg                        i_cfg,
    input  logic signed [bhs_pkg::AccelW-1:0]    i_accel,
    input  logic        [bhs_pkg::SpeedW-1:0]    i_speed,
    input  bhs_pkg::t_tick_flags                 i_flags,
    output bhs_pkg::t_hold_status                o_now,
    output bhs_pkg::t_hold_status                o_next
);

    logic                                 r_enabled, n_enabled;
    logic [bhs_pkg::LingerW-1:0]          r_count, n_count;
    logic signed [bhs_pkg::AccelW-1:0]    r_brake, n_brake;
    logic signed [bhs_pkg::AccelW-1:0]    r_prev, n_prev;
    logic                                 r_blind, n_blind;
    logic [bhs_pkg::BlindW-1:0]           r_blind_cnt, n_blind_cnt;
    logic                                 r_d1, n_d1;
    logic                                 r_d2, n_d2;
    logic                                 r_active, n_active;

    logic signed [bhs_pkg::AccelW:0]      diff;
    logic signed [bhs_pkg::AccelW:0]      step_pos;
    logic signed [bhs_pkg::AccelW:0]      delta;
    logic signed [bhs_pkg::AccelW-1:0]    ramp;
    logic                                 engage;

    // Jerk-limited ramp from the previous brake value toward the stop target.
    always_comb begin
        step_pos = $signed({{(bhs_pkg::AccelW + 1 - bhs_pkg::JerkW){1'b0}}, i_cfg.jerk_step});
        diff     = $signed({{(bhs_pkg::AccelW + 1 - bhs_pkg::TargetW){i_cfg.stop_target[
                       bhs_pkg::TargetW-1]}}, i_cfg.stop_target})
                   - $signed({r_prev[bhs_pkg::AccelW-1], r_prev});
        if (diff > step_pos) begin
            delta = step_pos;
        end else if (diff < -step_pos) begin
            delta = -step_pos;
        end else begin
            delta = diff;
        end
        ramp = r_prev + delta[bhs_pkg::AccelW-1:0];
    end

    always_comb begin
        engage      = i_accel[bhs_pkg::AccelW-1]
                      && ((i_flags.standby && (i_speed <= i_cfg.engage_speed)) || r_enabled);
        n_enabled   = r_enabled;
        n_count     = r_count;
        n_brake     = r_brake;
        n_prev      = r_prev;
        n_blind     = r_blind;
        n_blind_cnt = r_blind_cnt;
        n_d1        = r_d1;
        n_d2        = r_d2;

        if (engage) begin
            if (!r_enabled) begin
                n_count   = '0;
                n_brake   = '0;
                n_enabled = 1'b1;
                n_prev    = i_accel;
            end else begin
                n_brake = i_flags.is_stopping ? ramp : i_accel;
                n_prev  = n_brake;
            end
            if (n_count != '1) begin
                n_count = n_count + 1'b1;
            end
        end else begin
            if (r_enabled && (r_count < i_cfg.linger_ticks)) begin
                n_count = r_count + 1'b1;
            end else begin
                n_brake   = '0;
                n_enabled = 1'b0;
            end
        end

        if (i_flags.override_any) begin
            if (n_enabled) begin
                n_blind = 1'b1;
            end
            n_brake   = '0;
            n_enabled = 1'b0;
            n_d1      = 1'b0;
            n_d2      = 1'b0;
        end

        if (n_blind && (r_blind_cnt < i_cfg.blind_ticks)) begin
            n_blind_cnt = r_blind_cnt + 1'b1;
        end else begin
            n_blind     = 1'b0;
            n_blind_cnt = '0;
        end

        n_active = n_d2 || n_enabled;
        n_d2     = n_d1;
        n_d1     = n_enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_count     <= '0;
            r_brake     <= '0;
            r_prev      <= '0;
            r_blind     <= 1'b0;
            r_blind_cnt <= '0;
            r_d1        <= 1'b0;
            r_d2        <= 1'b0;
            r_active    <= 1'b0;
        end else if (i_step) begin
            r_enabled   <= n_enabled;
            r_count     <= n_count;
            r_brake     <= n_brake;
            r_prev      <= n_prev;
            r_blind     <= n_blind;
            r_blind_cnt <= n_blind_cnt;
            r_d1        <= n_d1;
            r_d2        <= n_d2;
            r_active    <= n_active;
        end
    end

    assign o_now  = '{enabled: r_enabled, active: r_active, blind: r_blind, brake_now: r_brake};
    assign o_next = '{enabled: n_enabled, active: n_active, blind: n_blind, brake_now: n_brake};

endmodule

// ===== hw/rtl/bhs_frame.sv =====
// ----------------------------------------------------------------------------
// bhs_frame: status frame builder
// Builds the eight payload bytes from the hold state and the beat's flags,
// with byte 7 as the XOR of bytes 0 to 6.
// ----------------------------------------------------------------------------
module bhs_frame (
    input  bhs_pkg::t_hold_status           i_status,
    input  logic                            i_release,
    input  logic                            i_switch,
    input  logic                            i_is_stopped,
    input  logic [3:0]                      i_msg_counter,
    input  logic                            i_to_powertrain,
    input  logic [bhs_pkg::OemW-1:0]        i_oem,
    output logic [bhs_pkg::FrameW-1:0]      o_frame
);

    logic [7:0]                       b [8];
    logic signed [bhs_pkg::AccelW:0]  sum;
    logic [9:0]                       sixteenths;
    logic [19:0]                      prod;
    logic [7:0]                       decel;

    // Divide by 48 as a shift by four and a multiply by the reciprocal of three;
    // exact for the sub-768 range left after saturation.
    always_comb begin
        sum        = $signed({i_status.brake_now[bhs_pkg::AccelW-1], i_status.brake_now})
                     + bhs_pkg::DecelOffset;
        sixteenths = sum[13:4];
        prod       = {10'd0, sixteenths} * {10'd0, bhs_pkg::RecipThree};
        if (sum <= 0) begin
            decel = 8'd0;
        end else if (sum >= bhs_pkg::DecelSatAt) begin
            decel = 8'hFF;
        end else begin
            decel = prod[18:11];
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i] = 8'd0;
        end
        if (!i_release && !i_switch) begin
            b[0] = {i_msg_counter, 4'd0};
            if (i_to_powertrain) begin
                b[3] = decel;
                b[4] = {1'b0, i_status.enabled, 1'b0, i_status.enabled, 3'd0,
                        (i_status.brake_now != '0)};
                b[5] = {7'd0, i_status.enabled};
            end else begin
                b[4] = 8'h10;
                b[5] = {7'd0, i_is_stopped};
            end
        end else begin
            b[0] = {i_msg_counter, i_oem[3:0]};
            for (int i = 1; i < 7; i++) begin
                b[i] = i_oem[8*i +: 8];
            end
        end
        b[7] = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
        for (int i = 0; i < 8; i++) begin
            o_frame[8*i +: 8] = b[i];
        end
    end

endmodule

// ===== hw/rtl/brake_hold_sequencer.sv =====
// ----------------------------------------------------------------------------
// brake_hold_sequencer: brake-hold sequencer with status frame builder
// Tick beats step the hold state; frame beats build the 8-byte status payload.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while results are taken, and
// returns exactly one result beat for each, in order. A result is loaded into
// the output register, and offered from there, once that register is empty or
// drained. A beat is captured in an input register, worked through one
// pass of compare, ramp, counter and frame logic, and the result lands in an
// output register; while a result waits the input register can still take one
// more beat, and the hold state is updated at the same edge that loads the
// result, so the following beat always sees the state left by the one before.
// Tick beats (tuser = 0) advance the hold, brake ramp, blind timer and release
// tail and return a zero frame; frame beats (tuser = 1) leave the state
// untouched and return the payload built from it. Configuration writes take
// effect at once and should be made only while no beat is in flight.
// ----------------------------------------------------------------------------
module brake_hold_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bhs_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [bhs_pkg::CfgDataW-1:0]      i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, lowest bit up: accel_ego[15:0], speed_ego[32:16], standby[33],
    // is_stopping[34], is_stopped[35], driver_override[36], oem_release[37],
    // oem_switch[38], msg_counter[42:39], to_powertrain[43], oem_bytes[99:44],
    // zero pad[103:100]
    input  logic [103:0]                      s_axis_tdata,
    // tuser: op[0]
    input  logic                              s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, lowest bit up: frame_bytes[63:0], brake_accel[79:64],
    // hold_enable[80], hold_active[81], radar_blind[82], zero pad[87:83]
    output logic [87:0]                       m_axis_tdata
);

    bhs_pkg::t_cfg         r_cfg;
    logic                  r_in_vld;
    logic [103:0]          r_in_data;
    logic                  r_in_op;
    logic                  r_out_vld;
    logic [87:0]           r_out_data;
    logic [87:0]           n_out_data;

    logic                  advance;
    logic                  is_tick;
    bhs_pkg::t_tick_flags  flags;
    bhs_pkg::t_hold_status st_now;
    bhs_pkg::t_hold_status st_next;
    bhs_pkg::t_hold_status st_res;
    logic [bhs_pkg::FrameW-1:0] frame;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jerk_step    <= bhs_pkg::JerkReset;
            r_cfg.stop_target  <= bhs_pkg::TargetReset;
            r_cfg.engage_speed <= bhs_pkg::SpeedReset;
            r_cfg.linger_ticks <= bhs_pkg::LingerReset;
            r_cfg.blind_ticks  <= bhs_pkg::BlindReset;
        end else if (i_cfg_we) begin
            case (bhs_pkg::t_cfg_idx'(i_cfg_idx))
                bhs_pkg::CFG_JERK_STEP: begin
                    r_cfg.jerk_step <= i_cfg_data[bhs_pkg::JerkW-1:0];
                end
                bhs_pkg::CFG_STOP_TARGET: begin
                    r_cfg.stop_target <= i_cfg_data[bhs_pkg::TargetW-1:0];
                end
                bhs_pkg::CFG_ENGAGE_SPEED: begin
                    r_cfg.engage_speed <= i_cfg_data[bhs_pkg::SpeedW-1:0];
                end
                bhs_pkg::CFG_LINGER_TICKS: begin
                    r_cfg.linger_ticks <= i_cfg_data[bhs_pkg::LingerW-1:0];
                end
                bhs_pkg::CFG_BLIND_TICKS: begin
                    r_cfg.blind_ticks <= i_cfg_data[bhs_pkg::BlindW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The held beat moves on whenever the output register is empty or being
    // drained this cycle; the input register refills in the same cycle.
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    assign is_tick = (bhs_pkg::t_op'(r_in_op) == bhs_pkg::OP_TICK);
    assign flags   = '{standby:      r_in_data[33],
                       is_stopping:  r_in_data[34],
                       override_any: r_in_data[36] | r_in_data[37] | r_in_data[38]};

    bhs_hold u_hold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && is_tick),
        .i_cfg   (r_cfg),
        .i_accel (r_in_data[15:0]),
        .i_speed (r_in_data[32:16]),
        .i_flags (flags),
        .o_now   (st_now),
        .o_next  (st_next)
    );

    // Frames are built from the state as it stands; they never change it.
    bhs_frame u_frame (
        .i_status        (st_now),
        .i_release       (r_in_data[37]),
        .i_switch        (r_in_data[38]),
        .i_is_stopped    (r_in_data[35]),
        .i_msg_counter   (r_in_data[42:39]),
        .i_to_powertrain (r_in_data[43]),
        .i_oem           (r_in_data[99:44]),
        .o_frame         (frame)
    );

    assign st_res     = is_tick ? st_next : st_now;
    assign n_out_data = {5'd0, st_res.blind, st_res.active, st_res.enabled,
                         st_res.brake_now, (is_tick ? {bhs_pkg::FrameW{1'b0}} : frame)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // An engaged hold always reports itself active.
    a_enable_implies_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[80] || m_axis_tdata[81]))
        else $error("hold engaged but not reported active");

    // Tick results carry an all-zero frame.
    a_tick_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_tick) |=> (m_axis_tdata[63:0] == '0))
        else $error("tick result carries a non-zero frame");

    // A full input register that cannot move on must be holding input back.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |-> !s_axis_tready)
        else $error("input accepted over a stalled beat");

    // Frame beats leave the hold state untouched.
    a_frame_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_tick) |=> (st_now == $past(st_now)))
        else $error("frame beat changed the hold state");
`endif

endmodule
